[hw/rtl/kti_pkg.sv]
// ----------------------------------------------------------------------------
// kti_pkg: shared types for the keyed interpolation table
// Item opcodes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int CHARGE_W = 7;
  localparam int COUNT_W  = 7;
  localparam int OP_W     = 2;
  localparam int HDR_W    = SLOT_W + INDEX_W + CHARGE_W + COUNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_POINT = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RD0,
    ST_CHK0,
    ST_CHKN,
    ST_SRCH,
    ST_SRCHW,
    ST_SEGA,
    ST_SEGB,
    ST_SEGC,
    ST_MUL,
    ST_MDIV,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/keyed_table_linear_interpolation.sv]
// ----------------------------------------------------------------------------
// keyed_table_linear_interpolation: keyed piecewise-linear lookup table
// Stores curves keyed by charge and interpolates a query energy, extrapolating below the first point.
// ----------------------------------------------------------------------------
// Load items (set key and count, write point) are taken in ST_IDLE. A query
// scans the curve keys one per cycle, reads the first and last points in
// ST_RD0, ST_CHK0 and ST_CHKN, binary-searches the point memory through its
// one read port with each probe taking ST_SRCH and then ST_SRCHW, reads the
// segment ends in ST_SEGA, ST_SEGB and ST_SEGC, then runs the shared
// multiply/divide unit, which forms the product and then the quotient, and
// clamps the result in ST_FIN. A stalled result receiver holds the query in
// ST_DONE. The next item is taken in the cycle after the result is loaded,
// and the block takes a new item while a finished result waits at the output.
module keyed_table_linear_interpolation #(
  parameter int CURVES     = 8,
  parameter int POINTS     = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // slot, point_index, charge, point_count, energy, point_value (low bit up)
  input  logic [((kti_pkg::HDR_W + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // opcode
  input  logic [kti_pkg::OP_W-1:0] in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // result_value
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // found, saturated
  output logic [1:0]             out_tuser
);
  import kti_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int OW  = ((DW + 7) / 8) * 8;
  localparam int CIW = (CURVES > 1) ? $clog2(CURVES) : 1;
  localparam int PW  = $clog2(POINTS);
  localparam int AW  = (CURVES * POINTS > 1) ? $clog2(CURVES * POINTS) : 1;
  localparam int SW  = 2 * DW + 2;

  // input fields
  logic [SLOT_W-1:0]   f_slot;
  logic [INDEX_W-1:0]  f_index;
  logic [CHARGE_W-1:0] f_charge;
  logic [COUNT_W-1:0]  f_count;
  logic [DW-1:0]       f_energy;
  logic [DW-1:0]       f_value;
  op_t                 f_op;

  assign f_slot   = in_tdata[SLOT_W-1:0];
  assign f_index  = in_tdata[SLOT_W+INDEX_W-1:SLOT_W];
  assign f_charge = in_tdata[SLOT_W+INDEX_W+CHARGE_W-1:SLOT_W+INDEX_W];
  assign f_count  = in_tdata[HDR_W-1:HDR_W-COUNT_W];
  assign f_energy = in_tdata[HDR_W+DW-1:HDR_W];
  assign f_value  = in_tdata[HDR_W+2*DW-1:HDR_W+DW];
  assign f_op     = op_t'(in_tuser);

  state_t state_r, state_nxt;

  logic                curve_valid_r  [CURVES];
  logic [CHARGE_W-1:0] curve_charge_r [CURVES];
  logic [COUNT_W-1:0]  curve_points_r [CURVES];

  logic [CHARGE_W-1:0] chg_r;
  logic [DW-1:0]       x_r;
  logic [CIW-1:0]      c_r;
  logic [CIW-1:0]      hit_r;
  logic                found_r;
  logic [COUNT_W-1:0]  npts_r;
  logic [PW-1:0]       lo_r, hi_r, mid_r;
  logic [DW-1:0]       e0_r, v0_r;
  logic [DW-1:0]       a_r, b_r, d_r;
  logic                neg_r;
  logic [DW-1:0]       res_r;
  logic                sat_r;
  logic                out_tvalid_r;
  logic [DW-1:0]       out_val_r;
  logic [1:0]          out_flags_r;

  logic                accept;
  logic                hit_now;
  logic                last_curve;
  logic [AW-1:0]       base;
  logic [AW-1:0]       raddr;
  logic [2*DW-1:0]     rdata_r;
  logic [DW-1:0]       rd_e, rd_v;
  logic [PW-1:0]       mid;
  logic [PW-1:0]       last_idx;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic                md_start;
  logic                md_done;
  logic [2*DW-1:0]     md_q;
  logic                out_free;
  logic signed [DW:0]  dv, dx;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] vmax_x, vmin_x;

  assign accept     = in_tvalid && in_tready;
  assign hit_now    = curve_valid_r[c_r] && (curve_charge_r[c_r] == chg_r);
  assign last_curve = c_r == CIW'(CURVES - 1);
  assign base       = AW'(hit_r) * AW'(POINTS);
  assign rd_e       = rdata_r[DW-1:0];
  assign rd_v       = rdata_r[2*DW-1:DW];
  assign mid        = PW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign last_idx   = PW'(npts_r - COUNT_W'(1));
  assign out_free   = !out_tvalid_r || out_tready;
  assign mem_we     = accept && (f_op == OP_POINT) && (int'(f_slot) < CURVES)
                      && (int'(f_index) < POINTS);
  assign waddr      = AW'(f_slot) * AW'(POINTS) + AW'(f_index);
  assign dv         = $signed({rd_v[DW-1], rd_v}) - $signed({v0_r[DW-1], v0_r});
  assign dx         = $signed({1'b0, x_r}) - $signed({1'b0, e0_r});
  assign sum        = neg_r ? $signed({{(SW-DW){v0_r[DW-1]}}, v0_r}) - $signed({2'b00, md_q})
                            : $signed({{(SW-DW){v0_r[DW-1]}}, v0_r}) + $signed({2'b00, md_q});
  assign vmax_x     = $signed({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  assign vmin_x     = ~vmax_x;

  kti_mem #(
    .DEPTH (CURVES * POINTS),
    .AW    (AW),
    .WIDTH (2 * DW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   ({f_value, f_energy}),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  kti_muldiv #(
    .DW (DW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (a_r),
    .b     (b_r),
    .d     (d_r),
    .done  (md_done),
    .q     (md_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && f_op == OP_QUERY) state_nxt = ST_MATCH;
      ST_MATCH: if (last_curve) state_nxt = (hit_now || found_r) ? ST_RD0 : ST_DONE;
      ST_RD0:   state_nxt = ST_CHK0;
      ST_CHK0:  state_nxt = (npts_r < COUNT_W'(2)) ? ST_DONE : ST_CHKN;
      ST_CHKN: begin
        if (x_r < e0_r) begin
          state_nxt = ST_SEGA;
        end else if (x_r >= rd_e) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH:  state_nxt = ((hi_r - lo_r) > PW'(1)) ? ST_SRCHW : ST_SEGA;
      ST_SRCHW: state_nxt = ST_SRCH;
      ST_SEGA:  state_nxt = ST_SEGB;
      ST_SEGB:  state_nxt = ST_SEGC;
      ST_SEGC:  state_nxt = (rd_e > e0_r) ? ST_MUL : ST_DONE;
      ST_MUL:   state_nxt = ST_MDIV;
      ST_MDIV:  if (md_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    md_start  = 1'b0;
    raddr     = base;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_CHK0:  raddr = base + AW'(last_idx);
      ST_SRCH:  raddr = base + AW'(mid);
      ST_SEGA:  raddr = base + AW'(lo_r);
      ST_SEGB:  raddr = base + AW'(lo_r) + AW'(1);
      ST_MUL:   md_start = 1'b1;
      default:  raddr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // curve key table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CURVES; i++) begin
        curve_valid_r[i]  <= 1'b0;
        curve_charge_r[i] <= '0;
        curve_points_r[i] <= '0;
      end
    end else if (accept && f_op == OP_SET && int'(f_slot) < CURVES) begin
      curve_charge_r[CIW'(f_slot)] <= f_charge;
      curve_points_r[CIW'(f_slot)] <= (int'(f_count) > POINTS) ? COUNT_W'(POINTS) : f_count;
      curve_valid_r[CIW'(f_slot)]  <= f_count != '0;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        chg_r   <= f_charge;
        x_r     <= f_energy;
        c_r     <= '0;
        found_r <= 1'b0;
        res_r   <= '0;
        sat_r   <= 1'b0;
      end
      ST_MATCH: begin
        if (hit_now) begin
          hit_r   <= c_r;
          found_r <= 1'b1;
          npts_r  <= curve_points_r[c_r];
        end
        c_r <= c_r + CIW'(1);
      end
      ST_CHK0: begin
        e0_r  <= rd_e;
        v0_r  <= rd_v;
        res_r <= rd_v;
      end
      ST_CHKN: begin
        lo_r  <= '0;
        hi_r  <= last_idx;
        res_r <= rd_v;
      end
      ST_SRCH:  mid_r <= mid;
      ST_SRCHW: begin
        if (x_r < rd_e) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r;
        end
      end
      ST_SEGB: begin
        e0_r <= rd_e;
        v0_r <= rd_v;
      end
      ST_SEGC: begin
        res_r <= v0_r;
        a_r   <= dv[DW] ? DW'(-dv) : DW'(dv);
        b_r   <= dx[DW] ? DW'(-dx) : DW'(dx);
        d_r   <= rd_e - e0_r;
        neg_r <= dv[DW] ^ dx[DW];
      end
      ST_FIN: begin
        if (sum > vmax_x) begin
          res_r <= vmax_x[DW-1:0];
          sat_r <= 1'b1;
        end else if (sum < vmin_x) begin
          res_r <= vmin_x[DW-1:0];
          sat_r <= 1'b1;
        end else begin
          res_r <= sum[DW-1:0];
        end
      end
      default: res_r <= res_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_val_r   <= res_r;
      out_flags_r <= {sat_r, found_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OW'(out_val_r);
  assign out_tuser  = out_flags_r;

  // a missing curve gives a zero result
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_flags_r[0] || out_val_r == '0))
    else $error("result nonzero without a matching curve");

  // clamping only happens on a found curve
  a_sat_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_flags_r[1] |-> out_flags_r[0])
    else $error("saturated without a matching curve");

  // search window never collapses
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> lo_r < hi_r)
    else $error("binary search window empty");

endmodule

[hw/rtl/kti_mem.sv]
// ----------------------------------------------------------------------------
// kti_mem: point store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kti_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one point
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read every cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

[hw/rtl/kti_muldiv.sv]
// ----------------------------------------------------------------------------
// kti_muldiv: shared multiply and restoring divide unit
// Computes floor(a*b/d): forms the product, then shifts in one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kti_muldiv #(
  parameter int DW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DW-1:0]   a,
  input  logic [DW-1:0]   b,
  input  logic [DW-1:0]   d,
  output logic            done,
  output logic [2*DW-1:0] q
);

  localparam int PW = 2 * DW;
  localparam int CW = $clog2(PW);

  logic [PW-1:0] p_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem2;
  logic          ge;

  // one restoring step
  assign rem2 = {rem_r, p_r[PW-1]};
  assign ge   = rem2 >= {1'b0, d};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: product, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      p_r   <= PW'(a) * PW'(b);
      rem_r <= '0;
    end else if (busy_r) begin
      p_r   <= {p_r[PW-2:0], ge};
      rem_r <= ge ? DW'(rem2 - {1'b0, d}) : DW'(rem2);
    end
  end

  assign done = done_r;
  assign q    = p_r;

endmodule

[test/keyed_table_linear_interpolation_checker.sv]
// ----------------------------------------------------------------------------
// keyed_table_linear_interpolation_checker: scoreboard for the lookup table
// Watches both stream channels and mirrors the curve table. It predicts the
// interpolated value, found and saturated flags of each query and compares
// every result item, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module keyed_table_linear_interpolation_checker #(
  parameter int CURVES     = 8,
  parameter int POINTS     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          pending
);
  import kti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic               found;
    logic               sat;
  } lookup_t;

  // Mirror of the curve table
  logic               key_valid [CURVES];
  logic [6:0]         key_charge [CURVES];
  logic [6:0]         key_count [CURVES];
  logic [31:0]        pt_energy [CURVES*POINTS];
  logic signed [31:0] pt_value [CURVES*POINTS];

  lookup_t expected_lookups[$];

  // Linear interpolation on one segment, exact quotient truncated toward zero
  function automatic void segment_interp(input longint v0, input longint v1,
                                         input longint e0, input longint e1,
                                         input longint x,
                                         output logic signed [31:0] r,
                                         output logic sat);
    longint dv, dx, de;
    logic neg;
    logic [95:0] prod, q;
    logic signed [99:0] acc;
    dv = v1 - v0;
    dx = x - e0;
    de = e1 - e0;
    neg = (dv < 0) != (dx < 0);
    prod = 96'(dv < 0 ? -dv : dv) * 96'(dx < 0 ? -dx : dx);
    q = prod / 96'(de);
    acc = v0;
    acc = neg ? acc - $signed({4'b0, q}) : acc + $signed({4'b0, q});
    sat = 1'b0;
    if (acc > 100'sd2147483647) begin
      r = 32'sh7fffffff;
      sat = 1'b1;
    end else if (acc < -100'sd2147483648) begin
      r = 32'sh80000000;
      sat = 1'b1;
    end else begin
      r = acc[31:0];
    end
  endfunction

  function automatic lookup_t lookup_curve(input logic [6:0] chg, input logic [31:0] x);
    lookup_t res;
    int hit, base, n, lo, hi, mid;
    res = '0;
    hit = -1;
    for (int c = 0; c < CURVES; c++) begin
      if (key_valid[c] && key_charge[c] == chg) hit = c;
    end
    if (hit < 0) return res;
    res.found = 1'b1;
    base = hit * POINTS;
    n = key_count[hit];
    if (n < 2) begin
      res.value = pt_value[base];
    end else if (x < pt_energy[base]) begin
      if (pt_energy[base+1] > pt_energy[base])
        segment_interp(pt_value[base], pt_value[base+1], pt_energy[base],
                       pt_energy[base+1], x, res.value, res.sat);
      else
        res.value = pt_value[base];
    end else if (x >= pt_energy[base+n-1]) begin
      res.value = pt_value[base+n-1];
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (x < pt_energy[base+mid]) hi = mid;
        else lo = mid;
      end
      if (pt_energy[base+lo+1] > pt_energy[base+lo] && x >= pt_energy[base+lo])
        segment_interp(pt_value[base+lo], pt_value[base+lo+1], pt_energy[base+lo],
                       pt_energy[base+lo+1], x, res.value, res.sat);
      else
        res.value = pt_value[base+lo];
    end
    return res;
  endfunction

  assign pending = expected_lookups.size();

  always @(posedge clk) begin
    logic [2:0]  slot;
    logic [5:0]  idx;
    logic [6:0]  chg, cnt;
    logic [31:0] eng;
    lookup_t     exp_res;
    if (!rst_n) begin
      errors <= 0;
      expected_lookups.delete();
      for (int c = 0; c < CURVES; c++) begin
        key_valid[c] = 1'b0;
        key_charge[c] = '0;
        key_count[c] = '0;
      end
    end else begin
      // Update the mirror or predict a result for each accepted item
      if (in_tvalid && in_tready) begin
        slot = in_tdata[2:0];
        idx  = in_tdata[8:3];
        chg  = in_tdata[15:9];
        cnt  = in_tdata[22:16];
        eng  = in_tdata[54:23];
        case (op_t'(in_tuser))
          OP_SET: begin
            if (cnt > POINTS) cnt = POINTS;
            key_charge[slot] = chg;
            key_count[slot]  = cnt;
            key_valid[slot]  = cnt != 0;
          end
          OP_POINT: begin
            pt_energy[slot*POINTS+idx] = eng;
            pt_value[slot*POINTS+idx]  = in_tdata[86:55];
          end
          OP_QUERY: expected_lookups.insert(expected_lookups.size(), lookup_curve(chg, eng));
          default: ;
        endcase
      end
      // Compare each result item against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          $error("result item with no query outstanding");
          errors <= errors + 1;
        end else begin
          exp_res = expected_lookups.pop_front();
          if (out_tdata !== exp_res.value || out_tuser[0] !== exp_res.found ||
              out_tuser[1] !== exp_res.sat)
            errors <= errors + 1;
          if (out_tdata !== exp_res.value)
            $error("result_value: expected %0d, got %0d", exp_res.value,
                   $signed(out_tdata));
          if (out_tuser[0] !== exp_res.found)
            $error("found: expected %0b, got %0b", exp_res.found, out_tuser[0]);
          if (out_tuser[1] !== exp_res.sat)
            $error("saturated: expected %0b, got %0b", exp_res.sat, out_tuser[1]);
        end
      end
    end
  end

endmodule

[test/keyed_table_linear_interpolation_tb.sv]
// ----------------------------------------------------------------------------
// keyed_table_linear_interpolation_tb: stimulus for the lookup table
// Loads every curve, runs directed corner queries and then a random mix of
// loads and queries with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module keyed_table_linear_interpolation_tb;
  import kti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  int          errors, pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          cyc = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyed_table_linear_interpolation uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  keyed_table_linear_interpolation_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .errors(errors), .pending(pending)
  );

  // Stall the receiver on a randomly chosen pattern that changes during the run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive one item and hold it until accepted; insert gaps between bursts
  task automatic drive_item(input op_t op, input logic [2:0] slot, input logic [5:0] idx,
                            input logic [6:0] chg, input logic [6:0] cnt,
                            input logic [31:0] eng, input logic [31:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, eng, cnt, chg, idx, slot};
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
  endtask

  task automatic set_curve(input logic [2:0] slot, input logic [6:0] chg,
                           input logic [6:0] cnt);
    drive_item(OP_SET, slot, '0, chg, cnt, '0, '0);
  endtask

  task automatic put_point(input logic [2:0] slot, input logic [5:0] idx,
                           input logic [31:0] eng, input logic [31:0] val);
    drive_item(OP_POINT, slot, idx, '0, '0, eng, val);
  endtask

  task automatic query(input logic [6:0] chg, input logic [31:0] eng);
    drive_item(OP_QUERY, '0, '0, chg, '0, eng, '0);
  endtask

  initial begin
    int sel;
    logic [5:0] idx;
    logic [2:0] slot;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill slot 7 completely and the first 16 points of the other slots;
    // slots 0 to 6 only ever get counts up to 16 so no query reads past them
    for (int s = 0; s < 8; s++) begin
      for (int i = 0; i < ((s == 7) ? 64 : 16); i++)
        put_point(s, i, (i + 1) << 20, $urandom);
      set_curve(s, s, (s == 7) ? 64 : 16);
    end

    // Below first, above last, exact point, mid segment
    query(0, 0);
    query(1, 32'hffffffff);
    query(2, 5 << 20);
    query(3, (9 << 20) + 12345);
    // Count above the table size, highest slot wins on a shared key
    set_curve(7, 3, 100);
    query(3, (40 << 20) + 777);
    // Single-point curve
    set_curve(6, 9, 1);
    query(9, 32'h12345678);
    // Extrapolation below the first point that clamps, then a query above the last
    put_point(5, 0, 1 << 20, 32'hc0000000);
    put_point(5, 1, 2 << 20, 32'h7fffffff);
    set_curve(5, 10, 2);
    query(10, 0);
    query(10, 32'hffffffff);
    // Equal neighbor energies
    put_point(4, 1, 1 << 20, 32'h00010000);
    set_curve(4, 11, 2);
    query(11, 0);
    query(11, 1 << 20);
    // Misses: unknown key, cleared slot
    query(127, 3 << 20);
    set_curve(2, 2, 0);
    query(2, 3 << 20);
    // Ignored item, last index of the last slot
    drive_item(OP_NOP, 3'h7, 6'h3f, 7'h7f, 7'h7f, 32'hffffffff, 32'hffffffff);
    put_point(7, 63, 32'hffffffff, 32'h80000000);

    // Random mix of loads and queries
    for (int n = 0; n < 190; n++) begin
      sel  = $urandom_range(0, 99);
      slot = $urandom_range(0, 7);
      idx  = (slot == 3'd7) ? $urandom_range(0, 63) : $urandom_range(0, 15);
      if (sel < 40) begin
        query(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15),
              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 70 << 20));
      end else if (sel < 75) begin
        put_point(slot, idx,
                  ($urandom_range(0, 7) == 0) ? $urandom
                                              : ((idx + 1) << 20) + $urandom_range(0, 1 << 19),
                  ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 24));
      end else if (sel < 94) begin
        if (slot == 3'd7)
          set_curve(slot,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, 64));
        else
          set_curve(slot,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
                                                : $urandom_range(1, 16));
      end else begin
        drive_item(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    in_tvalid <= 1'b0;

    // Let the checker register the last accepted item before draining
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
